>>> rtl/core/hbsd_pkg.sv
// package: constants and types shared by the huffman decoder modules
package hbsd_pkg;
  localparam int TableEntries = 256;
  localparam int MaxCodeBits  = 29;
  localparam int PositionBits = 12;
  localparam int SymBits      = $clog2(TableEntries);
  localparam int LenBits      = 5;
  localparam int HeightBits   = 13;
  localparam int OffsetBits   = 8;
  localparam int CfgIdxBits   = 1;
  localparam int CfgDataBits  = 13;
  localparam int QueueDepth   = 2;

  localparam logic [CfgIdxBits-1:0] CfgColumnHeight = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgValueOffset  = 1'b1;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeBit  = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [7:0]             entry_symbol;
    logic [MaxCodeBits-1:0] entry_code;
    logic [LenBits-1:0]     entry_length;
    logic                   data_bit;
    logic                   last_bit;
  } in_item_t;

  typedef struct packed {
    logic signed [8:0]       symbol_value;
    logic [PositionBits-1:0] row_index;
    logic [PositionBits-1:0] column_index;
    logic                    overlong_error;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic                   is_load;
    logic                   load_ok;
    logic [SymBits-1:0]     sym;
    logic [MaxCodeBits-1:0] code;
    logic [LenBits-1:0]     len;
    logic                   data_bit;
    logic                   last_bit;
  } cmd_t;
endpackage

>>> rtl/core/hbsd_stream_if.sv
// valid/ready channel interface
interface hbsd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/hbsd_front.sv
// front end: accepts items, classifies and masks loads, feeds the command queue
module hbsd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  hbsd_stream_if.sink      in_s,
  output hbsd_pkg::cmd_t   cmd_o,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i
);
  import hbsd_pkg::*;

  cmd_t q_q [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wr_q, rd_q;
  logic [$clog2(QueueDepth):0]   cnt_q;
  cmd_t c;
  logic push;
  logic [MaxCodeBits-1:0] mask;

  always_comb begin
    mask = {MaxCodeBits{1'b1}} >> (LenBits'(MaxCodeBits) - in_s.data.entry_length);
    c.is_load  = (in_s.data.mode == ModeLoad);
    c.load_ok  = (in_s.data.entry_length != '0) &&
                 (in_s.data.entry_length <= LenBits'(MaxCodeBits));
    c.sym      = in_s.data.entry_symbol[SymBits-1:0];
    c.code     = in_s.data.entry_code & mask;
    c.len      = in_s.data.entry_length;
    c.data_bit = in_s.data.data_bit;
    c.last_bit = in_s.data.last_bit;
  end

  assign in_s.ready  = (cnt_q != ($clog2(QueueDepth)+1)'(QueueDepth));
  assign push        = in_s.valid && in_s.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (cmd_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + ($clog2(QueueDepth)+1)'(push) - ($clog2(QueueDepth)+1)'(cmd_pop_i);
    end
  end
endmodule

>>> rtl/core/hbsd_back.sv
// back end: code table memory, sequential match search, position counters
module hbsd_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hbsd_pkg::cmd_t                      cmd_i,
  input  logic                                cmd_valid_i,
  output logic                                cmd_pop_o,
  input  logic [hbsd_pkg::HeightBits-1:0]     column_height_i,
  input  logic [hbsd_pkg::OffsetBits-1:0]     value_offset_i,
  hbsd_stream_if.source                       out_s
);
  import hbsd_pkg::*;

  typedef enum logic [1:0] {Idle, Search, Finish} state_e;

  localparam int EntBits = MaxCodeBits + LenBits;

  logic [EntBits-1:0]      mem [TableEntries];
  logic [TableEntries-1:0] valid_q;
  logic [EntBits-1:0]      rd_q;
  logic                    rd_valid_q;
  state_e                  state_q;
  logic [SymBits-1:0]      idx_q;
  logic [SymBits-1:0]      cmp_idx_q;
  logic                    cmp_live_q;
  logic                    found_q;
  logic [SymBits-1:0]      found_sym_q;
  logic [MaxCodeBits-1:0]  acc_q;
  logic [LenBits-1:0]      len_q;
  logic                    last_q;
  logic [PositionBits-1:0] row_q, col_q;
  out_item_t               out_q;
  logic                    out_valid_q;

  logic [MaxCodeBits-1:0] acc_n;
  logic [LenBits-1:0]     len_n;
  logic                   hit;
  logic [PositionBits:0]  height;
  logic [PositionBits:0]  row_inc;

  assign acc_n = {acc_q[MaxCodeBits-2:0], cmd_i.data_bit};
  assign len_n = len_q + 1'b1;
  assign hit   = cmp_live_q && rd_valid_q && (rd_q[LenBits-1:0] == len_q) &&
                 (rd_q[EntBits-1:LenBits] == acc_q);
  assign height = (column_height_i == '0 ||
                   column_height_i > HeightBits'(1 << PositionBits))
                  ? (PositionBits+1)'(1 << PositionBits)
                  : (PositionBits+1)'(column_height_i);
  assign row_inc = {1'b0, row_q} + 1'b1;

  assign cmd_pop_o   = cmd_valid_i && (state_q == Idle) && !out_valid_q;
  assign out_s.valid = out_valid_q;
  assign out_s.data  = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.is_load && cmd_i.load_ok) mem[cmd_i.sym] <= {cmd_i.code, cmd_i.len};
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; valid_q <= '0; idx_q <= '0; cmp_idx_q <= '0;
      cmp_live_q <= 1'b0; rd_valid_q <= 1'b0; found_q <= 1'b0; found_sym_q <= '0;
      acc_q <= '0; len_q <= '0; last_q <= 1'b0; row_q <= '0; col_q <= '0;
      out_q <= '0; out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_s.ready) out_valid_q <= 1'b0;
      rd_valid_q <= valid_q[idx_q];
      cmp_idx_q  <= idx_q;
      case (state_q)
        Idle: begin
          cmp_live_q <= 1'b0;
          if (cmd_pop_o) begin
            if (cmd_i.is_load) begin
              if (cmd_i.load_ok) valid_q[cmd_i.sym] <= 1'b1;
            end else begin
              acc_q <= acc_n; len_q <= len_n; last_q <= cmd_i.last_bit;
              found_q <= 1'b0;
              idx_q <= SymBits'(TableEntries - 1);
              state_q <= Search;
            end
          end
        end
        Search: begin
          // read pipeline: address in idx_q, compare on the registered read in the cycle after
          cmp_live_q <= 1'b1;
          if (hit && !found_q) begin
            found_q <= 1'b1; found_sym_q <= cmp_idx_q;
          end
          if (idx_q == '0) state_q <= Finish;
          else idx_q <= idx_q - 1'b1;
        end
        Finish: begin
          if (cmp_live_q) begin
            cmp_live_q <= 1'b0;
            if (hit && !found_q) begin
              found_q <= 1'b1; found_sym_q <= cmp_idx_q;
            end
          end else begin
            state_q <= Idle;
            if (found_q) begin
              out_q.symbol_value   <= 9'({1'b0, found_sym_q} - {1'b0, value_offset_i});
              out_q.row_index      <= row_q;
              out_q.column_index   <= col_q;
              out_q.overlong_error <= 1'b0;
              out_valid_q <= 1'b1;
              if (row_inc >= height) begin
                row_q <= '0; col_q <= col_q + 1'b1;
              end else row_q <= row_inc[PositionBits-1:0];
              acc_q <= '0; len_q <= '0;
            end else if (len_q >= LenBits'(MaxCodeBits)) begin
              out_q.symbol_value   <= '0;
              out_q.row_index      <= '0;
              out_q.column_index   <= '0;
              out_q.overlong_error <= 1'b1;
              out_valid_q <= 1'b1;
              acc_q <= '0; len_q <= '0;
            end else if (last_q) begin
              acc_q <= '0; len_q <= '0;
            end
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end
endmodule

>>> rtl/core/huffman_bit_serial_decoder_unit.sv
// top level: huffman bit-serial decoder with config registers
// in_s carries load items (mode 0: one table entry) and bit items (mode 1).
// out_s carries decoded symbols with row/column position, or an overlong
// error flag. Load items and unfinished bits give no output item.
// A front stage masks and queues items in a two-entry queue; the back
// stage handles one at a time. Loads are written to the table without a
// search. A bit item scans all 256 table entries, highest symbol first,
// through a registered memory read and one comparator; the back end takes
// no new item until that scan is done and its output register is empty.
// Results sit in an output register; while the receiver stalls the back
// end holds, and the queue keeps taking items until full.
// Reset clears table valid marks, the code accumulator, the position
// counters and restores column_height 8 and value_offset 123.
// Configuration writes (cfg_we_i) take effect the next cycle.
module huffman_bit_serial_decoder_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  hbsd_stream_if.sink                         in_s,
  hbsd_stream_if.source                       out_s,
  input  logic                                cfg_we_i,
  input  logic [hbsd_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [hbsd_pkg::CfgDataBits-1:0]    cfg_data_i
);
  import hbsd_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  logic [HeightBits-1:0] height_q;
  logic [OffsetBits-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HeightBits'(8);
      offset_q <= OffsetBits'(123);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgColumnHeight: height_q <= cfg_data_i[HeightBits-1:0];
        CfgValueOffset:  offset_q <= cfg_data_i[OffsetBits-1:0];
        default: ;
      endcase
    end
  end

  hbsd_front u_front (
    .clk_i, .rst_ni, .in_s,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop)
  );

  hbsd_back u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop),
    .column_height_i(height_q), .value_offset_i(offset_q), .out_s
  );
endmodule

>>> verif/huffman_bit_serial_decoder_unit_test.sv
// testbench: huffman bit-serial decoder, directed table then random streams vs predictor
module huffman_bit_serial_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hbsd_pkg::*;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxBits-1:0]  cfg_idx;
  logic [CfgDataBits-1:0] cfg_data;

  hbsd_stream_if #(.T(in_item_t))  in_if ();
  hbsd_stream_if #(.T(out_item_t)) out_if ();

  huffman_bit_serial_decoder_unit i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_s      (in_if),
    .out_s     (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // decoder model state
  bit                     tbl_valid [TableEntries];
  logic [MaxCodeBits-1:0] tbl_code  [TableEntries];
  int                     tbl_len   [TableEntries];
  logic [MaxCodeBits-1:0] acc_code;
  int                     acc_len;
  logic [PositionBits-1:0] row_cnt, col_cnt;
  int                     col_height;
  logic [7:0]             sym_offset;

  out_item_t expected_symbols [$];
  int errors, items_sent, symbols_seen, overlong_seen;
  int send_idle, recv_idle;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic bit decode_step(input in_item_t it, output out_item_t r);
    int found, h;
    logic [MaxCodeBits-1:0] m;
    r = '0;
    if (it.mode == ModeLoad) begin
      if (it.entry_length >= 1 && it.entry_length <= MaxCodeBits) begin
        m = (29'(1) << it.entry_length) - 29'(1);
        tbl_valid[it.entry_symbol] = 1'b1;
        tbl_len[it.entry_symbol]   = it.entry_length;
        tbl_code[it.entry_symbol]  = it.entry_code & m;
      end
      return 1'b0;
    end
    acc_code = {acc_code[MaxCodeBits-2:0], it.data_bit};
    acc_len++;
    found = -1;
    for (int s = TableEntries - 1; s >= 0; s--) begin
      if (tbl_valid[s] && tbl_len[s] == acc_len && tbl_code[s] == acc_code) begin
        found = s;
        break;
      end
    end
    if (found >= 0) begin
      h = (col_height == 0 || col_height > 4096) ? 4096 : col_height;
      r.symbol_value = 9'(found) - {1'b0, sym_offset};
      r.row_index    = row_cnt;
      r.column_index = col_cnt;
      if (int'(row_cnt) + 1 >= h) begin
        row_cnt = '0;
        col_cnt = col_cnt + 1'b1;
      end else begin
        row_cnt = row_cnt + 1'b1;
      end
      acc_code = '0;
      acc_len  = 0;
      return 1'b1;
    end
    if (acc_len >= MaxCodeBits) begin
      r.overlong_error = 1'b1;
      acc_code = '0;
      acc_len  = 0;
      return 1'b1;
    end
    if (it.last_bit) begin
      acc_code = '0;
      acc_len  = 0;
    end
    return 1'b0;
  endfunction

  function automatic in_item_t load_item(int sym, int code, int len);
    in_item_t it;
    it.mode         = ModeLoad;
    it.entry_symbol = 8'(sym);
    it.entry_code   = 29'(code);
    it.entry_length = 5'(len);
    it.data_bit     = 1'($urandom);
    it.last_bit     = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t bit_item(bit d, bit l);
    in_item_t it;
    it.mode         = ModeBit;
    it.entry_symbol = 8'($urandom);
    it.entry_code   = 29'($urandom);
    it.entry_length = 5'($urandom);
    it.data_bit     = d;
    it.last_bit     = l;
    return it;
  endfunction

  function automatic dir_row_t ld(int sym, int code, int len);
    dir_row_t d;
    d.it = load_item(sym, code, len);
    d.typed = 1'b0;
    d.res = '0;
    return d;
  endfunction

  function automatic dir_row_t bt(bit b, bit l, bit typed = 0, int val = 0, int row = 0);
    dir_row_t d;
    d.it = bit_item(b, l);
    d.typed = typed;
    d.res = '0;
    d.res.symbol_value = 9'(val);
    d.res.row_index = 12'(row);
    return d;
  endfunction

  task automatic send(in_item_t it, bit typed = 0, out_item_t typed_res = '0);
    out_item_t r;
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    if (decode_step(it, r)) expected_symbols.push_back(typed ? typed_res : r);
  endtask

  // queued items plus the one in the back end may still be scanning
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (4 * (TableEntries + 8)) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= 13'(value);
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (idx == CfgColumnHeight) col_height = value & 13'h1fff;
    else sym_offset = 8'(value);
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    out_item_t e, a;
    if (rst_n && out_if.valid && out_if.ready) begin
      a = out_if.data;
      if (a.overlong_error) overlong_seen++;
      else symbols_seen++;
      if (expected_symbols.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, actual %p", $time, a);
      end else begin
        e = expected_symbols.pop_front();
        check_field("symbol_value", e.symbol_value, a.symbol_value);
        check_field("row_index", e.row_index, a.row_index);
        check_field("column_index", e.column_index, a.column_index);
        check_field("overlong_error", e.overlong_error, a.overlong_error);
      end
    end
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    dir_row_t dir_rows [$];
    int heights [6] = '{8, 1, 4096, 0, 8191, 5};
    int offsets [6] = '{123, 0, 255, 7, 200, 128};
    int used_syms [$];
    int n, sym, len, target, pick;
    in_item_t it;

    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    acc_code = '0;
    acc_len = 0;
    row_cnt = '0;
    col_cnt = '0;
    col_height = 8;
    sym_offset = 8'd123;
    send_idle = 30;
    recv_idle = 83;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows = '{
      bt(1, 1),
      ld(0, 0, 1), ld(255, 29'h1fffffff, 1), ld(200, 1, 1),
      bt(1, 0, 1, 132, 0),
      bt(0, 0, 1, -123, 1),
      ld(10, 0, 0), ld(11, 0, 31),
      ld(0, 0, 29), ld(255, 29'h1fffffff, 29), ld(200, 2, 2),
      bt(1, 0), bt(0, 0, 1, 77, 2),
      bt(1, 1), bt(0, 1)
    };
    foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 30 : (ph < 4) ? 83 : 0;
      recv_idle = (ph < 2) ? 83 : (ph < 4) ? 30 : 0;
      if (ph > 0) begin
        drain();
        write_reg(CfgColumnHeight, heights[ph]);
        write_reg(CfgValueOffset, offsets[ph]);
      end
      // unary-style table over random symbols, leaves all-ones streams unmatched
      n = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(2, 8);
      used_syms.delete();
      for (int i = 0; i < n; i++) begin
        sym = (i == 0 && ph[0]) ? 255 : (i == 1 && ph[0]) ? 0 : $urandom_range(255);
        used_syms.push_back(sym);
        send(load_item(sym, ((1 << i) - 1) << 1 | ($urandom & 32'h7fff_fff8) << i, i + 1));
      end
      target = items_sent + 150;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          send(load_item($urandom_range(255), $urandom, $urandom_range(31)));
        end else if (pick < 8) begin
          for (int k = 0; k < MaxCodeBits; k++) send(bit_item(1'b1, 1'b0));
        end else if (pick < 20) begin
          len = $urandom_range(1, 5);
          for (int k = 0; k < len; k++) send(bit_item(1'($urandom), $urandom_range(3) == 0));
        end else begin
          sym = used_syms[$urandom_range(used_syms.size() - 1)];
          if (tbl_valid[sym] && tbl_len[sym] <= 20) begin
            len = tbl_len[sym];
            for (int k = len - 1; k >= 0; k--)
              send(bit_item(tbl_code[sym][k], k == 0 && $urandom_range(1)));
          end
        end
      end
    end
    drain();

    $display("ran %0d items over 6 register settings, %0d symbols and %0d overlong errors",
             items_sent, symbols_seen, overlong_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/core/hbsd_pkg.sv
rtl/core/hbsd_stream_if.sv
rtl/core/hbsd_front.sv
rtl/core/hbsd_back.sv
rtl/core/huffman_bit_serial_decoder_unit.sv
verif/huffman_bit_serial_decoder_unit_test.sv
